/* rtl/core/lwbcd_pkg.sv */
package lwbcd_pkg;

  localparam int SLOT_COUNT = 40;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int IDX_W      = 6;
  localparam int TAG_W      = 31;
  localparam int STAMP_W    = 32;
  localparam int CMD_W      = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_FETCH = 3'd0,
    CMD_ALLOC = 3'd1,
    CMD_MARK  = 3'd2,
    CMD_PIN   = 3'd3,
    CMD_FLUSH = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic mark;
    logic pin;
    logic flush_empty;
    logic issue;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic any_dirty;
    logic scan_end;
    logic op_flush;
  } dp_stat_t;

endpackage

/* rtl/core/lwbcd_ctrl.sv */
module lwbcd_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lwbcd_pkg::CMD_W-1:0] cmd,
  input  lwbcd_pkg::dp_stat_t        stat,
  output lwbcd_pkg::dp_cmd_t         ctl,
  output logic                       busy
);

  lwbcd_pkg::state_t state;
  lwbcd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lwbcd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lwbcd_pkg::ST_IDLE: begin
        if (start) begin
          unique case (cmd)
            lwbcd_pkg::CMD_FETCH, lwbcd_pkg::CMD_ALLOC: state_next = lwbcd_pkg::ST_SCAN;
            lwbcd_pkg::CMD_FLUSH: begin
              if (stat.any_dirty) state_next = lwbcd_pkg::ST_SCAN;
            end
            default: state_next = lwbcd_pkg::ST_IDLE;
          endcase
        end
      end
      lwbcd_pkg::ST_SCAN: begin
        if (stat.scan_end) state_next = lwbcd_pkg::ST_TAIL;
      end
      lwbcd_pkg::ST_TAIL: begin
        state_next = stat.op_flush ? lwbcd_pkg::ST_IDLE : lwbcd_pkg::ST_COMMIT;
      end
      lwbcd_pkg::ST_COMMIT: state_next = lwbcd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = (state != lwbcd_pkg::ST_IDLE);
    unique case (state)
      lwbcd_pkg::ST_IDLE: begin
        if (start) begin
          unique case (cmd)
            lwbcd_pkg::CMD_FETCH, lwbcd_pkg::CMD_ALLOC: ctl.load = 1'b1;
            lwbcd_pkg::CMD_MARK: ctl.mark = 1'b1;
            lwbcd_pkg::CMD_PIN:  ctl.pin  = 1'b1;
            lwbcd_pkg::CMD_FLUSH: begin
              ctl.load        = stat.any_dirty;
              ctl.flush_empty = !stat.any_dirty;
            end
            default: ctl = '0;
          endcase
        end
      end
      lwbcd_pkg::ST_SCAN:   ctl.issue  = 1'b1;
      lwbcd_pkg::ST_TAIL:   ctl = '0;
      lwbcd_pkg::ST_COMMIT: ctl.commit = 1'b1;
    endcase
  end

endmodule

/* rtl/core/lwbcd_dp.sv */
module lwbcd_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  lwbcd_pkg::dp_cmd_t            ctl,
  output lwbcd_pkg::dp_stat_t           stat,
  input  logic [lwbcd_pkg::CMD_W-1:0]   cmd,
  input  logic [lwbcd_pkg::TAG_W-1:0]   block_id,
  input  logic [lwbcd_pkg::IDX_W-1:0]   slot_index,
  output logic                          result_strobe,
  output logic [lwbcd_pkg::IDX_W-1:0]   slot,
  output logic                          hit,
  output logic                          fill_needed,
  output logic                          writeback_valid,
  output logic [lwbcd_pkg::TAG_W-1:0]   writeback_block,
  output logic [lwbcd_pkg::TAG_W-1:0]   placed_block,
  output logic                          last
);

  localparam int N  = lwbcd_pkg::SLOT_COUNT;
  localparam int SW = lwbcd_pkg::SLOT_W;
  localparam int IW = lwbcd_pkg::IDX_W;
  localparam int TW = lwbcd_pkg::TAG_W;
  localparam int MW = lwbcd_pkg::STAMP_W;

  logic [TW-1:0] tag_mem   [N];
  logic [MW-1:0] stamp_mem [N];

  logic [N-1:0]  valid;
  logic [N-1:0]  dirty;
  logic          pin_v;
  logic [IW-1:0] pin_slot;
  logic [MW-1:0] counter;
  logic [MW-1:0] counter_next;

  logic          op_fetch;
  logic          op_flush;
  logic [TW-1:0] blk;
  logic [SW-1:0] cnt;
  logic          eval_v;
  logic [SW-1:0] eval_idx;
  logic [TW-1:0] rd_tag;
  logic [MW-1:0] rd_stamp;

  logic          hit_found;
  logic [SW-1:0] hit_idx;
  logic          free_found;
  logic [SW-1:0] free_idx;
  logic          found;
  logic [MW-1:0] best;
  logic [SW-1:0] vic_idx;
  logic [TW-1:0] vic_tag;
  logic          have_unp;
  logic [SW-1:0] fu_idx;
  logic [TW-1:0] fu_tag;

  logic [N-1:0]  vd;
  logic [N-1:0]  above;
  logic          e_valid;
  logic          e_pinned;
  logic          flush_hit;
  logic [SW-1:0] v_idx;
  logic [TW-1:0] v_tag;
  logic          v_wb;
  logic [SW-1:0] w_idx;
  logic          idx_ok;

  logic          emit;
  logic [IW-1:0] r_slot;
  logic          r_hit;
  logic          r_fill;
  logic          r_wbv;
  logic [TW-1:0] r_wbb;
  logic [TW-1:0] r_placed;
  logic          r_last;

  assign vd            = valid & dirty;
  assign counter_next  = counter + 1'b1;
  assign e_valid       = valid[eval_idx];
  assign e_pinned      = pin_v && (pin_slot == IW'(eval_idx));
  assign flush_hit     = eval_v && op_flush && vd[eval_idx];
  assign idx_ok        = ({1'b0, slot_index} < (IW + 1)'(N));

  assign stat.any_dirty = |vd;
  assign stat.scan_end  = (cnt == SW'(N - 1));
  assign stat.op_flush  = op_flush;

  always_comb begin
    for (int j = 0; j < N; j++) begin
      above[j] = (SW'(j) > eval_idx);
    end
  end

  // victim: first empty slot, else oldest unpinned, else first unpinned
  always_comb begin
    if (free_found) begin
      v_idx = free_idx;
      v_tag = fu_tag;
    end else if (found) begin
      v_idx = vic_idx;
      v_tag = vic_tag;
    end else begin
      v_idx = fu_idx;
      v_tag = fu_tag;
    end
    v_wb  = valid[v_idx] && dirty[v_idx];
    w_idx = hit_found ? hit_idx : v_idx;
  end

  always_comb begin
    emit     = 1'b0;
    r_slot   = '0;
    r_hit    = 1'b0;
    r_fill   = 1'b0;
    r_wbv    = 1'b0;
    r_wbb    = '0;
    r_placed = '0;
    r_last   = 1'b0;
    priority if (ctl.mark || ctl.pin) begin
      emit   = 1'b1;
      r_slot = slot_index;
      r_last = 1'b1;
    end else if (ctl.flush_empty) begin
      emit   = 1'b1;
      r_last = 1'b1;
    end else if (flush_hit) begin
      emit   = 1'b1;
      r_slot = IW'(eval_idx);
      r_wbv  = 1'b1;
      r_wbb  = rd_tag;
      r_last = ~|(vd & above);
    end else if (ctl.commit) begin
      emit     = 1'b1;
      r_placed = blk;
      r_last   = 1'b1;
      if (hit_found) begin
        r_slot = IW'(hit_idx);
        r_hit  = 1'b1;
      end else begin
        r_slot = IW'(v_idx);
        r_fill = op_fetch;
        r_wbv  = v_wb;
        r_wbb  = v_wb ? v_tag : '0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= '0;
      dirty         <= '0;
      pin_v         <= 1'b0;
      pin_slot      <= '0;
      counter       <= '0;
      cnt           <= '0;
      eval_v        <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= emit;
      eval_v        <= ctl.issue;
      if (ctl.load) begin
        cnt <= '0;
      end else if (ctl.issue) begin
        cnt <= cnt + 1'b1;
      end
      if (ctl.mark && idx_ok && valid[slot_index[SW-1:0]]) begin
        dirty[slot_index[SW-1:0]] <= 1'b1;
      end
      if (ctl.pin) begin
        pin_v    <= 1'b1;
        pin_slot <= slot_index;
      end
      if (flush_hit) begin
        dirty[eval_idx] <= 1'b0;
      end
      if (ctl.commit) begin
        counter <= counter_next;
        if (!hit_found) begin
          valid[v_idx] <= 1'b1;
          dirty[v_idx] <= !op_fetch;
        end
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    eval_idx <= cnt;
    if (ctl.load) begin
      op_fetch   <= (cmd == lwbcd_pkg::CMD_FETCH);
      op_flush   <= (cmd == lwbcd_pkg::CMD_FLUSH);
      blk        <= block_id;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      found      <= 1'b0;
      have_unp   <= 1'b0;
      best       <= '1;
    end else if (eval_v && !op_flush) begin
      if (op_fetch && e_valid && (rd_tag == blk) && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= eval_idx;
      end
      if (!e_valid) begin
        if (!free_found) begin
          free_found <= 1'b1;
          free_idx   <= eval_idx;
        end
      end else if (!e_pinned) begin
        if (!have_unp) begin
          have_unp <= 1'b1;
          fu_idx   <= eval_idx;
          fu_tag   <= rd_tag;
        end
        if (rd_stamp < best) begin
          found   <= 1'b1;
          best    <= rd_stamp;
          vic_idx <= eval_idx;
          vic_tag <= rd_tag;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      rd_tag   <= tag_mem[cnt];
      rd_stamp <= stamp_mem[cnt];
    end
    if (ctl.commit && !hit_found) begin
      tag_mem[v_idx] <= blk;
    end
    if (ctl.commit) begin
      stamp_mem[w_idx] <= counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      slot            <= r_slot;
      hit             <= r_hit;
      fill_needed     <= r_fill;
      writeback_valid <= r_wbv;
      writeback_block <= r_wbb;
      placed_block    <= r_placed;
      last            <= r_last;
    end
  end

endmodule

/* rtl/core/lru_writeback_block_cache_directory.sv */
// Channel   Handshake                    Fields
// command   start, busy (start & !busy)  cmd, block_id, slot_index
// result    result_strobe (one cycle)    slot, hit, fill_needed, writeback_valid,
//                                        writeback_block, placed_block, last
//
// Fetch and alloc walk the directory one slot per cycle through the single
// read port of the tag/stamp memories. Mark-dirty, pin and an empty flush
// are answered from the idle state without a walk; a flush with dirty slots
// walks the directory and gives one result per dirty slot.
// Reset is synchronous; valid, dirty, pin and use counter clear at once.
// Results cannot be held off: each one shows for exactly one cycle.
module lru_writeback_block_cache_directory (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [lwbcd_pkg::CMD_W-1:0]   cmd,
  input  logic [lwbcd_pkg::TAG_W-1:0]   block_id,
  input  logic [lwbcd_pkg::IDX_W-1:0]   slot_index,
  output logic                          result_strobe,
  output logic [lwbcd_pkg::IDX_W-1:0]   slot,
  output logic                          hit,
  output logic                          fill_needed,
  output logic                          writeback_valid,
  output logic [lwbcd_pkg::TAG_W-1:0]   writeback_block,
  output logic [lwbcd_pkg::TAG_W-1:0]   placed_block,
  output logic                          last
);

  lwbcd_pkg::dp_cmd_t  ctl;
  lwbcd_pkg::dp_stat_t stat;

  lwbcd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  lwbcd_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .stat            (stat),
    .cmd             (cmd),
    .block_id        (block_id),
    .slot_index      (slot_index),
    .result_strobe   (result_strobe),
    .slot            (slot),
    .hit             (hit),
    .fill_needed     (fill_needed),
    .writeback_valid (writeback_valid),
    .writeback_block (writeback_block),
    .placed_block    (placed_block),
    .last            (last)
  );

endmodule

/* dv/tb_lru_writeback_block_cache_directory.sv */
module tb_lru_writeback_block_cache_directory;
  timeunit 1ns;
  timeprecision 1ps;

  import lwbcd_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;
  localparam int POOL_SIZE     = 48;
  localparam int RANDOM_ITEMS  = 220;
  localparam int DRAIN_AT      = 130;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic [TAG_W-1:0] blk;
    logic [IDX_W-1:0] idx;
    logic             drain;
  } dir_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] slot;
    logic             hit;
    logic             fill;
    logic             wbv;
    logic [TAG_W-1:0] wbb;
    logic [TAG_W-1:0] placed;
    logic             last;
  } dir_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [CMD_W-1:0] cmd = '0;
  logic [TAG_W-1:0] block_id = '0;
  logic [IDX_W-1:0] slot_index = '0;
  logic             result_strobe;
  logic [IDX_W-1:0] slot;
  logic             hit;
  logic             fill_needed;
  logic             writeback_valid;
  logic [TAG_W-1:0] writeback_block;
  logic [TAG_W-1:0] placed_block;
  logic             last;

  lru_writeback_block_cache_directory dut (.*);

  initial forever #5 clk = ~clk;

  // directory shadow
  bit               slot_ok  [SLOT_COUNT];
  bit [TAG_W-1:0]   slot_blk [SLOT_COUNT];
  bit               slot_mod [SLOT_COUNT];
  bit [STAMP_W-1:0] slot_age [SLOT_COUNT];
  bit [STAMP_W-1:0] use_ctr;
  bit               pin_on;
  bit [IDX_W-1:0]   pin_at;

  dir_item_t   item_q[$];
  dir_result_t due_responses[$];
  logic [TAG_W-1:0] block_pool [POOL_SIZE];
  dir_item_t   next_item;
  dir_result_t mon_got;
  dir_result_t mon_exp;
  int n_accepted = 0;
  int n_total = 0;
  int n_mismatch = 0;
  int gap_pct;

  function automatic int oldest_slot();
    logic [STAMP_W-1:0] best;
    int vic;
    int first_unp;
    bit found;
    bit have;
    best = '1;
    vic = 0;
    first_unp = 0;
    found = 1'b0;
    have = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!slot_ok[i]) return i;
      if (!(pin_on && pin_at == i)) begin
        if (!have) begin
          have = 1'b1;
          first_unp = i;
        end
        if (slot_age[i] < best) begin
          best = slot_age[i];
          vic = i;
          found = 1'b1;
        end
      end
    end
    return found ? vic : first_unp;
  endfunction

  task automatic apply_directory_cmd(input logic [CMD_W-1:0] op,
                                     input logic [TAG_W-1:0] blk,
                                     input logic [IDX_W-1:0] idx);
    dir_result_t r;
    int hit_at;
    int v;
    int n;
    int k;
    r = '0;
    case (op)
      CMD_FETCH, CMD_ALLOC: begin
        hit_at = -1;
        if (op == CMD_FETCH) begin
          for (int i = 0; i < SLOT_COUNT; i++)
            if (hit_at < 0 && slot_ok[i] && slot_blk[i] == blk) hit_at = i;
        end
        use_ctr++;
        r.placed = blk;
        r.last = 1'b1;
        if (hit_at >= 0) begin
          slot_age[hit_at] = use_ctr;
          r.slot = IDX_W'(hit_at);
          r.hit = 1'b1;
        end else begin
          v = oldest_slot();
          r.slot = IDX_W'(v);
          r.fill = (op == CMD_FETCH);
          r.wbv = slot_ok[v] && slot_mod[v];
          r.wbb = r.wbv ? slot_blk[v] : '0;
          slot_ok[v] = 1'b1;
          slot_blk[v] = blk;
          slot_age[v] = use_ctr;
          slot_mod[v] = (op == CMD_ALLOC);
        end
        due_responses.push_back(r);
      end
      CMD_MARK: begin
        if (idx < SLOT_COUNT && slot_ok[idx]) slot_mod[idx] = 1'b1;
        r.slot = idx;
        r.last = 1'b1;
        due_responses.push_back(r);
      end
      CMD_PIN: begin
        pin_on = 1'b1;
        pin_at = idx;
        r.slot = idx;
        r.last = 1'b1;
        due_responses.push_back(r);
      end
      CMD_FLUSH: begin
        n = 0;
        for (int i = 0; i < SLOT_COUNT; i++)
          if (slot_ok[i] && slot_mod[i]) n++;
        if (n == 0) begin
          r.last = 1'b1;
          due_responses.push_back(r);
        end else begin
          k = 0;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_ok[i] && slot_mod[i]) begin
              k++;
              r = '0;
              r.slot = IDX_W'(i);
              r.wbv = 1'b1;
              r.wbb = slot_blk[i];
              r.last = (k == n);
              slot_mod[i] = 1'b0;
              due_responses.push_back(r);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic add_item(input logic [CMD_W-1:0] op, input logic [TAG_W-1:0] blk,
                          input logic [IDX_W-1:0] idx, input logic drain);
    dir_item_t it;
    it.op = op;
    it.blk = blk;
    it.idx = idx;
    it.drain = drain;
    item_q.push_back(it);
  endtask

  function automatic logic [TAG_W-1:0] pick_block();
    if ($urandom_range(99, 0) < 85) return block_pool[$urandom_range(POOL_SIZE - 1, 0)];
    return TAG_W'($urandom);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_directory_cmd(cmd, block_id, slot_index);
        n_accepted++;
      end
      if (!start || !busy) begin
        gap_pct = (n_accepted < n_total / 3) ? 17 :
                  (n_accepted < 2 * n_total / 3) ? 66 : 0;
        if (item_q.size() != 0 && $urandom_range(99, 0) >= gap_pct &&
            !(item_q[0].drain && due_responses.size() != 0)) begin
          next_item = item_q.pop_front();
          start <= 1'b1;
          cmd <= next_item.op;
          block_id <= next_item.blk;
          slot_index <= next_item.idx;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      mon_got.slot = slot;
      mon_got.hit = hit;
      mon_got.fill = fill_needed;
      mon_got.wbv = writeback_valid;
      mon_got.wbb = writeback_block;
      mon_got.placed = placed_block;
      mon_got.last = last;
      if (due_responses.size() == 0) begin
        if (n_mismatch < REPORT_LIMIT)
          $display("unexpected result: slot=%0d wbv=%0b wbb=%h placed=%h last=%0b",
                   slot, writeback_valid, writeback_block, placed_block, last);
        n_mismatch++;
      end else begin
        mon_exp = due_responses.pop_front();
        if (mon_got !== mon_exp) begin
          if (n_mismatch < REPORT_LIMIT) begin
            $display("mismatch exp slot=%0d hit=%0b fill=%0b wbv=%0b wbb=%h placed=%h last=%0b",
                     mon_exp.slot, mon_exp.hit, mon_exp.fill, mon_exp.wbv, mon_exp.wbb,
                     mon_exp.placed, mon_exp.last);
            $display("         got slot=%0d hit=%0b fill=%0b wbv=%0b wbb=%h placed=%h last=%0b",
                     mon_got.slot, mon_got.hit, mon_got.fill, mon_got.wbv, mon_got.wbb,
                     mon_got.placed, mon_got.last);
          end
          n_mismatch++;
        end
      end
    end
  end

  initial begin
    int roll;
    int n_rand;
    block_pool[0] = '0;
    block_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) block_pool[i] = TAG_W'($urandom);

    // directed
    add_item(CMD_FLUSH, '0, '0, 1'b0);                  // empty flush
    add_item(CMD_FETCH, '0, '1, 1'b0);
    add_item(CMD_FETCH, '1, '0, 1'b0);
    add_item(CMD_FETCH, '0, '0, 1'b0);                  // hit
    add_item(CMD_ALLOC, '1, '1, 1'b0);                  // duplicate block
    add_item(CMD_FETCH, '1, '0, 1'b0);                  // hits lowest copy
    add_item(CMD_MARK, '1, 6'd0, 1'b0);
    add_item(CMD_MARK, '0, IDX_W'(SLOT_COUNT - 1), 1'b0); // invalid slot
    add_item(CMD_MARK, '0, '1, 1'b0);                   // out of range
    add_item(CMD_PIN, '0, 6'd4, 1'b0);                  // pin an empty slot
    add_item(CMD_FETCH, 31'h2AAAAAAA, 6'h2A, 1'b0);
    add_item(CMD_FETCH, 31'h55555555, 6'h15, 1'b0);     // takes pinned empty slot
    add_item(CMD_RSVD_FIRST, '1, '1, 1'b0);
    add_item(CMD_RSVD_LAST, '1, '1, 1'b0);
    add_item(CMD_FLUSH, '1, '1, 1'b0);
    add_item(CMD_FLUSH, '0, '0, 1'b0);
    add_item(CMD_PIN, '1, '1, 1'b0);                    // pin out of range
    add_item(CMD_PIN, '0, 6'd0, 1'b0);
    add_item(CMD_ALLOC, 31'h01234567, 6'h3F, 1'b0);
    add_item(CMD_MARK, '0, 6'd3, 1'b0);

    // random: mostly fetch/alloc over a pool slightly larger than the directory
    n_rand = 0;
    while (n_rand < RANDOM_ITEMS) begin
      roll = $urandom_range(99, 0);
      if (roll < 48) begin
        add_item(CMD_FETCH, pick_block(), IDX_W'($urandom), n_rand == DRAIN_AT);
      end else if (roll < 62) begin
        add_item(CMD_ALLOC, pick_block(), IDX_W'($urandom), n_rand == DRAIN_AT);
      end else if (roll < 77) begin
        add_item(CMD_MARK, TAG_W'($urandom),
                 ($urandom_range(99, 0) < 85) ? IDX_W'($urandom_range(SLOT_COUNT - 1, 0)) :
                 IDX_W'($urandom_range(63, SLOT_COUNT)), n_rand == DRAIN_AT);
      end else if (roll < 84) begin
        add_item(CMD_PIN, TAG_W'($urandom),
                 ($urandom_range(99, 0) < 90) ? IDX_W'($urandom_range(SLOT_COUNT - 1, 0)) :
                 IDX_W'($urandom_range(63, SLOT_COUNT)), n_rand == DRAIN_AT);
      end else if (roll < 93) begin
        add_item(CMD_FLUSH, TAG_W'($urandom), IDX_W'($urandom), n_rand == DRAIN_AT);
      end else begin
        add_item(CMD_RSVD_FIRST + CMD_W'($urandom_range(2, 0)), TAG_W'($urandom),
                 IDX_W'($urandom), 1'b0);
        n_rand--;
      end
      n_rand++;
    end
    n_total = item_q.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < n_total) @(posedge clk);
    while (due_responses.size() != 0) @(posedge clk);
    repeat (SLOT_COUNT + 8) @(posedge clk);

    if (n_mismatch == 0 && due_responses.size() == 0) begin
      $display("tb_lru_writeback_block_cache_directory: PASS");
    end else begin
      $display("tb_lru_writeback_block_cache_directory: FAIL");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("tb_lru_writeback_block_cache_directory: FAIL");
    $finish;
  end

endmodule
